// ----- hw/rtl/mks_pkg.sv -----
`timescale 1ns / 1ps

package mks_pkg;

  // Matrix geometry
  localparam int ROW_COUNT = 4;
  localparam int COL_COUNT = 10;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W     = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;

  // Field widths
  localparam int SETTLE_W    = 8;
  localparam int DEBOUNCE_W  = 16;
  localparam int COL_LVL_W   = 10;
  localparam int ROW_DRV_W   = 4;
  localparam int KEY_CODE_W  = 6;
  localparam int KEY_CHAR_W  = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b1;

  localparam logic [SETTLE_W-1:0]   SETTLE_RST   = 8'd5;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd20000;

  // Stream payload widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  // Keymap ROM
  localparam int MAP_ROWS = 4;
  localparam int MAP_COLS = 10;
  localparam logic [KEY_CHAR_W-1:0] KEYMAP [MAP_ROWS][MAP_COLS] = '{
    '{7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30},
    '{7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50},
    '{7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h0A},
    '{7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h20, 7'h00, 7'h00}
  };

  typedef enum logic [1:0] {
    MODE_PRESS    = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_RELEASE  = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic [SETTLE_W-1:0]   settle_ticks;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ROW_DRV_W-1:0]  row_drive;
    logic                  key_valid;
    logic [KEY_CODE_W-1:0] key_code;
    logic [KEY_CHAR_W-1:0] key_char;
  } scan_res_t;

  // Active-low row lines: row r pulls bit ROW_COUNT-1-r low.
  function automatic logic [ROW_DRV_W-1:0] row_drive_f(logic [ROW_W-1:0] row);
    logic [ROW_COUNT-1:0] drv;
    drv = '1;
    for (int r = 0; r < ROW_COUNT; r++) begin
      if (32'(row) == r) begin
        drv[ROW_COUNT-1-r] = 1'b0;
      end
    end
    return ROW_DRV_W'(drv);
  endfunction

  function automatic logic [KEY_CHAR_W-1:0] keymap_f(logic [ROW_W-1:0] row,
                                                     logic [COL_W-1:0] col);
    logic [KEY_CHAR_W-1:0] ch;
    ch = '0;
    for (int r = 0; r < MAP_ROWS; r++) begin
      for (int c = 0; c < MAP_COLS; c++) begin
        if (32'(row) == r && 32'(col) == c) begin
          ch = KEYMAP[r][c];
        end
      end
    end
    return ch;
  endfunction

endpackage

// ----- hw/rtl/mks_cfg_regs.sv -----
`timescale 1ns / 1ps

module mks_cfg_regs import mks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SETTLE:   cfg_d.settle_ticks   = cfg_data_i[SETTLE_W-1:0];
        CFG_DEBOUNCE: cfg_d.debounce_ticks = cfg_data_i[DEBOUNCE_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks   <= SETTLE_RST;
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/mks_scan_core.sv -----
`timescale 1ns / 1ps

module mks_scan_core import mks_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [COL_LVL_W-1:0] col_levels_i,
  input  cfg_t                 cfg_i,
  output scan_res_t            res_o
);

  logic [ROW_W-1:0]      scan_row_q, scan_row_d;
  logic [SETTLE_W-1:0]   settle_cnt_q, settle_cnt_d;
  logic [DEBOUNCE_W-1:0] debounce_cnt_q, debounce_cnt_d;
  scan_mode_e            scan_mode_q, scan_mode_d;

  logic [ROW_W-1:0] row_cur;
  logic             hit;
  logic [COL_W-1:0] hit_col;
  logic             last_row;

  // Lowest pressed column of the driven row.
  always_comb begin
    hit     = 1'b0;
    hit_col = '0;
    for (int c = COL_COUNT - 1; c >= 0; c--) begin
      if (!col_levels_i[c]) begin
        hit     = 1'b1;
        hit_col = COL_W'(c);
      end
    end
  end

  assign row_cur  = (32'(scan_row_q) >= ROW_COUNT) ? '0 : scan_row_q;
  assign last_row = (32'(row_cur) + 1 >= ROW_COUNT);

  // Next state
  always_comb begin
    scan_row_d     = row_cur;
    settle_cnt_d   = settle_cnt_q;
    debounce_cnt_d = debounce_cnt_q;
    scan_mode_d    = scan_mode_q;
    unique case (scan_mode_q)
      MODE_DEBOUNCE: begin
        if (debounce_cnt_q < cfg_i.debounce_ticks) begin
          debounce_cnt_d = debounce_cnt_q + 1'b1;
        end else begin
          scan_mode_d  = MODE_RELEASE;
          scan_row_d   = '0;
          settle_cnt_d = '0;
        end
      end
      MODE_RELEASE: begin
        if (settle_cnt_q < cfg_i.settle_ticks) begin
          settle_cnt_d = settle_cnt_q + 1'b1;
        end else begin
          settle_cnt_d = '0;
          if (hit) begin
            scan_row_d = '0;
          end else if (last_row) begin
            scan_mode_d = MODE_PRESS;
            scan_row_d  = '0;
          end else begin
            scan_row_d = row_cur + 1'b1;
          end
        end
      end
      default: begin
        if (settle_cnt_q < cfg_i.settle_ticks) begin
          settle_cnt_d = settle_cnt_q + 1'b1;
        end else begin
          settle_cnt_d = '0;
          if (hit) begin
            scan_mode_d    = MODE_DEBOUNCE;
            debounce_cnt_d = '0;
          end else begin
            scan_mode_d = MODE_PRESS;
            scan_row_d  = last_row ? '0 : row_cur + 1'b1;
          end
        end
      end
    endcase
  end

  // Result of this tick
  always_comb begin
    res_o           = '0;
    res_o.row_drive = row_drive_f(row_cur);
    if (scan_mode_q != MODE_DEBOUNCE && scan_mode_q != MODE_RELEASE &&
        settle_cnt_q >= cfg_i.settle_ticks && hit) begin
      res_o.key_valid = 1'b1;
      res_o.key_code  = KEY_CODE_W'(32'(row_cur) * COL_COUNT + 32'(hit_col));
      res_o.key_char  = keymap_f(row_cur, hit_col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q     <= '0;
      settle_cnt_q   <= '0;
      debounce_cnt_q <= '0;
      scan_mode_q    <= MODE_PRESS;
    end else if (step_i) begin
      scan_row_q     <= scan_row_d;
      settle_cnt_q   <= settle_cnt_d;
      debounce_cnt_q <= debounce_cnt_d;
      scan_mode_q    <= scan_mode_d;
    end
  end

endmodule

// ----- hw/rtl/matrix_keypad_scanner.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Signals                                   Payload
// s_axis    in   s_axis_tvalid_i/tready_o/tdata_i          one tick: column levels
// m_axis    out  m_axis_tvalid_o/tready_i/tdata_o/tuser_o  row drive, key code/char
// cfg       in   cfg_valid_i/ready_o/index_i/data_i        settle / debounce ticks
//
// One tick beat is taken per clock; its result lands in the output register
// in the next cycle. The scan state and the result register are the only stage.
// A waiting result stalls input only while the output side holds tready low.
// rst_ni clears the scan state to press scan at row 0 and loads the
// configuration reset values; the block takes a beat right after reset.

module matrix_keypad_scanner import mks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,   // [9:0] col_levels

  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,   // [3:0] row_drive, [9:4] key_code,
                                                  // [16:10] key_char
  output logic                  m_axis_tuser_o,   // [0] key_valid

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg;
  scan_res_t res;
  scan_res_t res_q;
  logic      out_valid_q, out_valid_d;
  logic      step;

  // Take a beat whenever the output register is empty or being drained.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  mks_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Scan state advances only on an accepted tick.
  mks_scan_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .col_levels_i (s_axis_tdata_i[COL_LVL_W-1:0]),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // Output register: load on accept, drop valid once the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.key_valid;
  assign m_axis_tdata_o  = M_TDATA_W'({res_q.key_char, res_q.key_code, res_q.row_drive});

endmodule
